// File: rtl/core/prrts_pkg.sv
// prrts_pkg: shared types, codes and defaults for the task scheduler
// no dependencies
`default_nettype none
package prrts_pkg;
  localparam int MaxTasksDef = 16;
  localparam int PrioLevelsDef = 32;
  localparam int FuncW = 3;
  localparam int IdW = 4;
  localparam int PrioW = 5;
  localparam int TimeW = 64;
  localparam int DelayW = 32;
  localparam int KindW = 2;
  localparam int QDepth = 2;

  localparam logic [FuncW-1:0] FN_CREATE = 3'd0;
  localparam logic [FuncW-1:0] FN_READY = 3'd1;
  localparam logic [FuncW-1:0] FN_SUSPEND = 3'd2;
  localparam logic [FuncW-1:0] FN_SCHED = 3'd3;
  localparam logic [FuncW-1:0] FN_SLEEP = 3'd4;
  localparam logic [FuncW-1:0] FN_REG = 3'd5;
  localparam logic [FuncW-1:0] FN_UNREG = 3'd6;
  localparam logic [FuncW-1:0] FN_TICK = 3'd7;

  localparam logic [KindW-1:0] EV_DONE = 2'd0;
  localparam logic [KindW-1:0] EV_TIMEOUT = 2'd1;
  localparam logic [KindW-1:0] EV_WOKEN = 2'd2;
  localparam logic [KindW-1:0] EV_YIELD = 2'd3;

  localparam logic [1:0] RS_NONE = 2'd0;
  localparam logic [1:0] RS_READY = 2'd1;
  localparam logic [1:0] RS_SUSP = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [IdW-1:0] task_id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] deadline;
    logic [DelayW-1:0] delay;
  } cmd_t;
endpackage
`default_nettype wire

// File: rtl/core/prrts_front.sv
// prrts_front: command intake and a two-deep command queue
// depends on prrts_pkg
`default_nettype none
module prrts_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire prrts_pkg::cmd_t cmd_in,
  output logic q_valid,
  output prrts_pkg::cmd_t q_cmd,
  input  wire logic q_pop
);
  import prrts_pkg::*;
  cmd_t q_r [QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic push;

  assign push = start && !busy;
  assign busy = (cnt_r == 2'(QDepth));
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
    end
    if (push) q_r[wr_r] <= cmd_in;
  end
endmodule
`default_nettype wire

// File: rtl/core/prrts_back.sv
// prrts_back: executes queued commands against scheduler state
// depends on prrts_pkg
`default_nettype none
module prrts_back #(
  parameter int MAX_TASKS = prrts_pkg::MaxTasksDef,
  parameter int PRIORITY_LEVELS = prrts_pkg::PrioLevelsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire prrts_pkg::cmd_t q_cmd,
  output logic q_pop,
  output logic out_valid,
  output logic [prrts_pkg::KindW-1:0] out_event_kind,
  output logic [prrts_pkg::IdW-1:0] out_task_id_out,
  output logic [prrts_pkg::IdW-1:0] out_current_task,
  output logic out_current_is_idle,
  output logic out_last
);
  import prrts_pkg::*;
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_EXEC = 6'b000010, S_REM = 6'b000100,
    S_ADD = 6'b001000, S_TICK = 6'b010000, S_DONE = 6'b100000
  } st_t;

  st_t st_r;
  cmd_t c_r;
  logic [PW-1:0] prio_r [MAX_TASKS];
  logic [1:0] rs_r [MAX_TASKS];
  logic [TW-1:0] qnext_r [MAX_TASKS];
  logic [TW-1:0] qhead_r [PRIORITY_LEVELS];
  logic [TW-1:0] qtail_r [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] bmap_r;
  logic [TimeW-1:0] dl_r [MAX_TASKS];
  logic [MAX_TASKS-1:0] armed_r, wakes_r;
  logic [TimeW-1:0] now_r;
  logic [TW-1:0] run_r, tgt_r, cur_r;
  logic idle_r;
  logic [CW-1:0] scan_r, walk_r;
  logic [PW-1:0] newp_r;
  logic [4:0] emit_cnt_r;
  logic [IdW-1:0] id_ok;
  logic idok, created;
  logic [PW-1:0] top_p;
  logic [PW-1:0] tp;

  assign idok = 32'(q_cmd.task_id) < MAX_TASKS;
  assign id_ok = q_cmd.task_id;

  always_comb begin
    top_p = '0;
    for (int p = 0; p < PRIORITY_LEVELS; p++) if (bmap_r[p]) top_p = PW'(p);
  end

  assign tp = prio_r[tgt_r];
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign created = rs_r[tgt_r] != RS_NONE;

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      st_r <= S_IDLE;
      bmap_r <= '0;
      armed_r <= '0;
      wakes_r <= '0;
      now_r <= '0;
      run_r <= '0;
      idle_r <= 1'b1;
      for (int i = 0; i < MAX_TASKS; i++) begin
        rs_r[i] <= RS_NONE;
        prio_r[i] <= '0;
      end
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            c_r <= q_cmd;
            tgt_r <= TW'(id_ok);
            st_r <= idok ? S_EXEC : S_DONE;
            if (q_cmd.func == FN_SCHED || q_cmd.func == FN_SLEEP
                || q_cmd.func == FN_TICK) st_r <= S_EXEC;
            if (q_cmd.func == FN_SLEEP) tgt_r <= run_r;
          end
        end
        S_EXEC: begin
          st_r <= S_DONE;
          case (c_r.func)
            FN_CREATE: begin
              armed_r[tgt_r] <= 1'b0;
              newp_r <= (32'(c_r.prio) < PRIORITY_LEVELS) ? PW'(c_r.prio)
                                                         : PW'(PRIORITY_LEVELS - 1);
              walk_r <= '0;
              cur_r <= qhead_r[tp];
              st_r <= S_REM;
            end
            FN_READY: if (created) st_r <= S_ADD;
            FN_SUSPEND: if (created) begin
              walk_r <= '0; cur_r <= qhead_r[tp]; st_r <= S_REM;
            end
            FN_SCHED: begin
              if (bmap_r != '0) begin
                if (qhead_r[top_p] != qtail_r[top_p]) begin
                  qhead_r[top_p] <= qnext_r[qhead_r[top_p]];
                  qnext_r[qtail_r[top_p]] <= qhead_r[top_p];
                  qtail_r[top_p] <= qhead_r[top_p];
                  run_r <= qnext_r[qhead_r[top_p]];
                end else run_r <= qhead_r[top_p];
                idle_r <= 1'b0;
              end else begin
                run_r <= '0; idle_r <= 1'b1;
              end
            end
            FN_SLEEP: if (!idle_r && created) begin
              if (!armed_r[tgt_r]) begin
                armed_r[tgt_r] <= 1'b1;
                wakes_r[tgt_r] <= 1'b1;
                dl_r[tgt_r] <= now_r + TimeW'(c_r.delay);
              end
              walk_r <= '0; cur_r <= qhead_r[tp]; st_r <= S_REM;
            end
            FN_REG: if (created && !armed_r[tgt_r]) begin
              armed_r[tgt_r] <= 1'b1;
              wakes_r[tgt_r] <= 1'b0;
              dl_r[tgt_r] <= c_r.deadline;
            end
            FN_UNREG: if (created) armed_r[tgt_r] <= 1'b0;
            default: begin
              now_r <= now_r + TimeW'(c_r.delay);
              scan_r <= '0;
              emit_cnt_r <= '0;
              st_r <= S_TICK;
            end
          endcase
        end
        S_REM: begin
          // removal: head check then one list hop per cycle
          if (rs_r[tgt_r] != RS_READY || !bmap_r[tp]) st_r <= S_ADD;
          else if (walk_r == '0 && qhead_r[tp] == tgt_r) begin
            if (qtail_r[tp] == tgt_r) bmap_r[tp] <= 1'b0;
            else qhead_r[tp] <= qnext_r[tgt_r];
            st_r <= S_ADD;
          end else if (walk_r == CW'(MAX_TASKS) || cur_r == qtail_r[tp]) begin
            st_r <= S_ADD;
          end else if (qnext_r[cur_r] == tgt_r) begin
            qnext_r[cur_r] <= qnext_r[tgt_r];
            if (qtail_r[tp] == tgt_r) qtail_r[tp] <= cur_r;
            st_r <= S_ADD;
          end else begin
            cur_r <= qnext_r[cur_r];
            walk_r <= walk_r + 1'b1;
          end
        end
        S_ADD: begin
          // reached from remove, from ready or from a woken sleeper
          logic [PW-1:0] ap;
          logic doadd;
          ap = tp;
          doadd = 1'b1;
          if (c_r.func == FN_CREATE) ap = newp_r;
          if (c_r.func == FN_SUSPEND || c_r.func == FN_SLEEP) doadd = 1'b0;
          if (c_r.func == FN_CREATE) prio_r[tgt_r] <= newp_r;
          if (!doadd) rs_r[tgt_r] <= RS_SUSP;
          else if (rs_r[tgt_r] != RS_READY || c_r.func == FN_CREATE) begin
            if (bmap_r[ap] && !(c_r.func == FN_CREATE && rs_r[tgt_r] == RS_READY
                && ap == tp && qhead_r[tp] == tgt_r && qtail_r[tp] == tgt_r)) begin
              qnext_r[qtail_r[ap]] <= tgt_r;
            end else begin
              qhead_r[ap] <= tgt_r;
              bmap_r[ap] <= 1'b1;
            end
            qtail_r[ap] <= tgt_r;
            rs_r[tgt_r] <= RS_READY;
          end
          st_r <= (c_r.func == FN_TICK) ? S_TICK : S_DONE;
        end
        S_TICK: begin
          if (scan_r == CW'(MAX_TASKS) || emit_cnt_r == 5'd16) begin
            st_r <= S_DONE;
          end else begin
            scan_r <= scan_r + 1'b1;
            if (armed_r[TW'(scan_r)] && now_r >= dl_r[TW'(scan_r)]) begin
              armed_r[TW'(scan_r)] <= 1'b0;
              emit_cnt_r <= emit_cnt_r + 1'b1;
              out_valid <= 1'b1;
              out_task_id_out <= IdW'(scan_r);
              out_current_task <= IdW'(run_r);
              out_current_is_idle <= idle_r;
              out_last <= 1'b0;
              out_event_kind <= EV_TIMEOUT;
              if (wakes_r[TW'(scan_r)]) begin
                out_event_kind <= EV_WOKEN;
                tgt_r <= TW'(scan_r);
                st_r <= S_ADD;
              end
            end
          end
        end
        default: begin
          out_valid <= 1'b1;
          out_event_kind <= (c_r.func == FN_TICK) ? EV_YIELD : EV_DONE;
          out_task_id_out <= '0;
          out_current_task <= IdW'(run_r);
          out_current_is_idle <= idle_r;
          out_last <= 1'b1;
          st_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/priority_round_robin_task_scheduler_top.sv
// channel  | handshake       | payload
// in       | start / busy    | in_func in_task_id in_priority_req in_deadline_ms in_delay_ms
// out      | out_valid strobe| out_event_kind out_task_id_out out_current_task ...
// a command passes the back end's idle, execute and done states; suspend, sleep and create walk
// the priority list for up to MAX_TASKS hops; a tick scans one task a cycle for expiry, pausing
// to re-queue each woken sleeper, and stops at 16 events. reset clears control and task status.
// results are one-cycle strobes; the receiver cannot stall, a 2-word queue takes input.
// top level: front queue and back executor; depends on prrts_pkg, prrts_front, prrts_back
`default_nettype none
module priority_round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = prrts_pkg::MaxTasksDef,
  parameter int PRIORITY_LEVELS = prrts_pkg::PrioLevelsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [prrts_pkg::FuncW-1:0] in_func,
  input  wire logic [prrts_pkg::IdW-1:0] in_task_id,
  input  wire logic [prrts_pkg::PrioW-1:0] in_priority_req,
  input  wire logic [prrts_pkg::TimeW-1:0] in_deadline_ms,
  input  wire logic [prrts_pkg::DelayW-1:0] in_delay_ms,
  output logic out_valid,
  output logic [prrts_pkg::KindW-1:0] out_event_kind,
  output logic [prrts_pkg::IdW-1:0] out_task_id_out,
  output logic [prrts_pkg::IdW-1:0] out_current_task,
  output logic out_current_is_idle,
  output logic out_last
);
  import prrts_pkg::*;
  cmd_t cmd_in, q_cmd;
  logic q_valid, q_pop;
  assign cmd_in = '{func: in_func, task_id: in_task_id, prio: in_priority_req,
                    deadline: in_deadline_ms, delay: in_delay_ms};
  prrts_front u_front (.clk, .rst_n, .start, .busy, .cmd_in, .q_valid, .q_cmd, .q_pop);
  prrts_back #(.MAX_TASKS(MAX_TASKS), .PRIORITY_LEVELS(PRIORITY_LEVELS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop, .out_valid, .out_event_kind,
    .out_task_id_out, .out_current_task, .out_current_is_idle, .out_last);
endmodule
`default_nettype wire
